[design/three_voice_sine_synth_macros.svh]
`ifndef THREE_VOICE_SINE_SYNTH_MACROS_SVH
`define THREE_VOICE_SINE_SYNTH_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[design/tss_pkg.sv]
`default_nettype none

package tss_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int NOTE_WIDTH   = 4;
   localparam int MAG_WIDTH    = 14;
   // Incoming sample plus three full-scale voices fits in 18 signed bits.
   localparam int ACC_WIDTH    = 18;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NOTE_VOICE_ZERO = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NOTE_VOICE_TWO  = 2'd2;
   localparam int NOTE_REGS = 3;

   localparam logic [NOTE_WIDTH-1:0] NOTE_MAX = 4'd11;

   localparam longint unsigned AMPLITUDE   = 64'd10666;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Phase increment per note, 32-bit fraction of one cycle.
   localparam logic [31:0] STEP_TABLE [12] = '{
      32'd42852281, 32'd45400044, 32'd48099738, 32'd50959154,
      32'd53989979, 32'd57200004, 32'd60600917, 32'd64204405,
      32'd68022153, 32'd72069746, 32'd76354974, 32'd80893420
   };

   // Taylor series divisors (k-1)*k for k = 3, 5, ... 19.
   localparam longint unsigned TAYLOR_DIV [9] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
   };

   typedef struct packed {
      logic                        valid;
      logic                        last;
      logic signed [ACC_WIDTH-1:0] acc;
   } tss_link_type;

   // Quarter-wave sine magnitude scaled to AMPLITUDE, computed in Q30 fixed point; evaluated at elaboration only.
   function automatic logic [MAG_WIDTH-1:0] quarter_sine(input int unsigned r,
                                                         input int unsigned qbits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned quarter;
      logic            subtract;
      quarter  = 64'd1 << qbits;
      subtract = 1'b1;
      if (r == 0) begin
         return '0;
      end
      if (64'(r) >= quarter) begin
         return MAG_WIDTH'(AMPLITUDE);
      end
      x    = (HALF_PI_Q30 * 64'(r)) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int j = 0; j < 9; j++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[j];
         if (subtract) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
         subtract = ~subtract;
      end
      return MAG_WIDTH'((AMPLITUDE * sum) >> 30);
   endfunction

endpackage

`default_nettype wire

[design/tss_cell.sv]
`default_nettype none

module tss_cell #(
   parameter int SINE_ADDR_BITS = 10,
   parameter int PHASE_WIDTH    = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic [tss_pkg::NOTE_WIDTH-1:0]    note,
   input  wire tss_pkg::tss_link_type             link_i,
   output      tss_pkg::tss_link_type             link_o
);

   localparam int QBITS   = SINE_ADDR_BITS - 2;
   localparam int QUARTER = 1 << QBITS;

   logic [tss_pkg::MAG_WIDTH-1:0] quarter_rom [QUARTER+1];

   for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
      assign quarter_rom[i] = tss_pkg::quarter_sine(i, QBITS);
   end

   logic [PHASE_WIDTH-1:0]          phase_ff, phase_in;
   logic                            valid_ff, valid_in;
   logic                            last_ff;
   logic signed [tss_pkg::ACC_WIDTH-1:0] acc_ff;

   logic [tss_pkg::NOTE_WIDTH-1:0]  note_sat;
   logic [PHASE_WIDTH-1:0]          step;
   logic [SINE_ADDR_BITS-1:0]       addr;
   logic [1:0]                      quad;
   logic [QBITS-1:0]                r;
   logic [QBITS:0]                  rom_idx;
   logic [tss_pkg::MAG_WIDTH-1:0]   mag;
   logic [tss_pkg::ACC_WIDTH-1:0]   mag_ext;
   logic [tss_pkg::ACC_WIDTH-1:0]   sine_val;
   logic signed [tss_pkg::ACC_WIDTH-1:0] acc_in;

   always_comb begin
      note_sat = (note > tss_pkg::NOTE_MAX) ? tss_pkg::NOTE_MAX : note;
      step     = PHASE_WIDTH'(tss_pkg::STEP_TABLE[note_sat] >> (32 - PHASE_WIDTH));
      addr     = phase_ff[PHASE_WIDTH-1 -: SINE_ADDR_BITS];
      quad     = addr[SINE_ADDR_BITS-1 -: 2];
      r        = addr[QBITS-1:0];
      // mirror the index on the falling quarter
      rom_idx  = quad[0] ? ((QBITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
      mag      = quarter_rom[rom_idx];
      mag_ext  = tss_pkg::ACC_WIDTH'(mag);
      sine_val = quad[1] ? (~mag_ext + 1'b1) : mag_ext;
      acc_in   = link_i.acc + $signed(sine_val);
      valid_in = link_i.valid;
      phase_in = phase_ff;
      if (advance && link_i.valid) begin
         phase_in = phase_ff + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (advance) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff  <= acc_in;
         last_ff <= link_i.last;
      end
   end

   assign link_o.valid = valid_ff;
   assign link_o.last  = last_ff;
   assign link_o.acc   = acc_ff;

endmodule

`default_nettype wire

[design/tss_out_stage.sv]
`default_nettype none

module tss_out_stage (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tss_pkg::tss_link_type               link_i,
   input  wire logic                                rsp_tready,
   output      logic                                rsp_tvalid,
   output      logic [tss_pkg::SAMPLE_WIDTH-1:0]    rsp_tdata,
   output      logic                                rsp_tlast,
   output      logic                                advance
);

   localparam int OVF_BITS = tss_pkg::ACC_WIDTH - tss_pkg::SAMPLE_WIDTH + 1;

   logic                               valid_ff;
   logic [tss_pkg::SAMPLE_WIDTH-1:0]   data_ff, data_in;
   logic                               last_ff;
   logic [OVF_BITS-1:0]                top_bits;

   assign advance = ~valid_ff | rsp_tready;

   always_comb begin
      top_bits = link_i.acc[tss_pkg::ACC_WIDTH-1 -: OVF_BITS];
      if (top_bits == '0 || top_bits == '1) begin
         data_in = link_i.acc[tss_pkg::SAMPLE_WIDTH-1:0];
      end else if (link_i.acc[tss_pkg::ACC_WIDTH-1]) begin
         // clamp to most negative
         data_in = {1'b1, {(tss_pkg::SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         data_in = {1'b0, {(tss_pkg::SAMPLE_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= link_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
         last_ff <= link_i.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

[design/three_voice_sine_synth.sv]
// Three-voice sine oscillator that mixes onto an incoming sample stream. Each
// req transaction is one sample slot: tdata carries the existing buffer sample,
// tlast marks the last slot of a buffer request. Every voice owns a phase
// accumulator stepped by its note's equal-tempered increment; the top phase bits
// read a quarter-wave sine table, and the voices are summed onto the sample with
// saturation to 16 bits. The voices form a chain of cells, one table lookup and
// add per cell, followed by a saturating output register, so the block takes one
// sample every cycle while rsp is not stalled, and each result is registered
// in every cell, then in the output register. A rsp stall holds the whole chain.
// Note registers take effect on the next sample; write them only while idle.
`default_nettype none

`include "three_voice_sine_synth_macros.svh"

module three_voice_sine_synth #(
   parameter int VOICES         = 3,
   parameter int SINE_ADDR_BITS = 10,
   parameter int PHASE_WIDTH    = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   input  wire logic [tss_pkg::SAMPLE_WIDTH-1:0]       req_tdata,   // [15:0] mix_in
   input  wire logic                                   req_tlast,   // end_of_block
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output      logic [tss_pkg::SAMPLE_WIDTH-1:0]       rsp_tdata,   // [15:0] sample_out
   output      logic                                   rsp_tlast,   // last
   input  wire logic                                   csr_we,
   input  wire logic [tss_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [tss_pkg::NOTE_WIDTH-1:0]         csr_wdata
);

   logic [tss_pkg::NOTE_WIDTH-1:0] note_ff [tss_pkg::NOTE_REGS];
   logic [tss_pkg::NOTE_WIDTH-1:0] note_in [tss_pkg::NOTE_REGS];

   tss_pkg::tss_link_type link [VOICES+1];
   logic                  advance;

   always_comb begin
      for (int i = 0; i < tss_pkg::NOTE_REGS; i++) begin
         note_in[i] = note_ff[i];
      end
      // drop writes beyond the last note register
      if (csr_we && (csr_index inside
                     {[tss_pkg::CSR_NOTE_VOICE_ZERO:tss_pkg::CSR_NOTE_VOICE_TWO]})) begin
         note_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tss_pkg::NOTE_REGS; i++) begin
            note_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < tss_pkg::NOTE_REGS; i++) begin
            note_ff[i] <= note_in[i];
         end
      end
   end

   assign req_tready   = advance;
   assign link[0].valid = req_tvalid;
   assign link[0].last  = req_tlast;
   assign link[0].acc   = tss_pkg::ACC_WIDTH'($signed(req_tdata));

   for (genvar v = 0; v < VOICES; v++) begin : g_voice
      tss_cell #(
         .SINE_ADDR_BITS (SINE_ADDR_BITS),
         .PHASE_WIDTH    (PHASE_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .note    (note_ff[v]),
         .link_i  (link[v]),
         .link_o  (link[v+1])
      );
   end

   tss_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .link_i     (link[VOICES]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .advance    (advance)
   );

   `TSS_ASSERT_NOW(a_stall_holds_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `TSS_ASSERT_NEXT(a_accept_enters_chain, clock, reset, req_tvalid && req_tready, link[1].valid)
   `TSS_ASSERT_NEXT(a_bubble_reaches_out, clock, reset, advance && !link[VOICES].valid, !rsp_tvalid)

endmodule

`default_nettype wire
